// ===== hw/rtl/assert_macros.svh =====
// Shared assertion macros, clocked on the rising edge and idle during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lpg_pkg.sv =====
`timescale 1ns / 1ps

package lpg_pkg;

  // Field widths of the pixel interface
  localparam int COORD_W  = 11;
  localparam int WIDTH_W  = 12;
  localparam int INDEX_W  = 22;
  localparam int COLOUR_W = 32;

  // Default coordinate datapath width
  localparam int COORD_BITS_DEF = 11;

  // Row pitch after reset
  localparam logic [WIDTH_W-1:0] LINE_PITCH_RESET = 12'd1680;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

endpackage

// ===== hw/rtl/line_pixel_generator_core.sv =====
`timescale 1ns / 1ps

// An accepted transaction passes through the stage 1 register and then the output register.
// Throughput: one transaction per cycle unless a stalled output holds the pipeline; the
// error update and step feed stage 1 combinationally, and the index multiply-add sits in the second stage.
// Reset (rst, synchronous, active high): no line active, pipeline empty,
// row pitch back to 1680.
module line_pixel_generator_core #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpg_pkg::WIDTH_W-1:0]   cfg_data,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [lpg_pkg::COORD_W-1:0]   start_x,
  input  logic [lpg_pkg::COORD_W-1:0]   start_y,
  input  logic [lpg_pkg::COORD_W-1:0]   end_x,
  input  logic [lpg_pkg::COORD_W-1:0]   end_y,
  input  logic [lpg_pkg::COLOUR_W-1:0]  line_colour,
  // pixel channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          pixel_valid,
  output logic [lpg_pkg::COORD_W-1:0]   pixel_x,
  output logic [lpg_pkg::COORD_W-1:0]   pixel_y,
  output logic [lpg_pkg::INDEX_W-1:0]   pixel_index,
  output logic [lpg_pkg::COLOUR_W-1:0]  pixel_colour,
  output logic                          last_pixel
);
  import lpg_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int ERRW  = COORD_BITS + 2;
  localparam int WIDE  = (COORD_BITS > COORD_W) ? COORD_BITS : COORD_W;
  localparam int PRODW = (COORD_BITS + WIDTH_W > INDEX_W) ? COORD_BITS + WIDTH_W : INDEX_W;

  // config register, always ready
  logic [WIDTH_W-1:0] line_pitch;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pitch <= LINE_PITCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_pitch <= cfg_data;
    end
  end

  // line state
  logic [CB-1:0]          cur_x, cur_y, target_x, target_y;
  logic [CB-1:0]          delta_x, delta_y;
  logic                   step_x_neg, step_y_neg;
  logic signed [ERRW-1:0] error_term;
  logic [COLOUR_W-1:0]    held_colour;
  logic                   line_active;

  logic [CB-1:0]          cur_x_next, cur_y_next, target_x_next, target_y_next;
  logic [CB-1:0]          delta_x_next, delta_y_next;
  logic                   step_x_neg_next, step_y_neg_next;
  logic signed [ERRW-1:0] error_term_next;
  logic [COLOUR_W-1:0]    held_colour_next;
  logic                   line_active_next;

  // stage 1 result register
  logic                s1_v, s1_pv, s1_last;
  logic [CB-1:0]       s1_x, s1_y;
  logic [COLOUR_W-1:0] s1_colour;

  logic                s1_pv_next, s1_last_next;
  logic [CB-1:0]       s1_x_next, s1_y_next;
  logic [COLOUR_W-1:0] s1_colour_next;

  // handshake
  logic in_fire, out_en;
  assign out_en   = !out_valid || !out_stall;
  assign in_stall = s1_v && !out_en;
  assign in_fire  = in_valid && !in_stall;

  // input coordinates taken modulo 2^COORD_BITS
  logic [WIDE-1:0] sx_w, sy_w, ex_w, ey_w;
  logic [CB-1:0]   x0, y0, x1, y1;
  assign sx_w = WIDE'(start_x);
  assign sy_w = WIDE'(start_y);
  assign ex_w = WIDE'(end_x);
  assign ey_w = WIDE'(end_y);
  assign x0   = sx_w[CB-1:0];
  assign y0   = sy_w[CB-1:0];
  assign x1   = ex_w[CB-1:0];
  assign y1   = ey_w[CB-1:0];

  // setup terms for a start
  logic [CB-1:0] dx_start, dy_start;
  assign dx_start = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
  assign dy_start = (y1 >= y0) ? (y1 - y0) : (y0 - y1);

  // step tests on the error before the update
  logic signed [ERRW-1:0] dx_s, dy_s;
  logic                   take_x, take_y;
  assign dx_s   = $signed({2'b00, delta_x});
  assign dy_s   = $signed({2'b00, delta_y});
  assign take_x = error_term > -dx_s;
  assign take_y = error_term < dy_s;

  // state update and emitted pixel
  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    target_x_next    = target_x;
    target_y_next    = target_y;
    delta_x_next     = delta_x;
    delta_y_next     = delta_y;
    step_x_neg_next  = step_x_neg;
    step_y_neg_next  = step_y_neg;
    error_term_next  = error_term;
    held_colour_next = held_colour;
    line_active_next = line_active;

    case (cmd)
      CMD_START: begin
        cur_x_next       = x0;
        cur_y_next       = y0;
        target_x_next    = x1;
        target_y_next    = y1;
        step_x_neg_next  = !(x0 < x1);
        step_y_neg_next  = !(y0 < y1);
        delta_x_next     = dx_start;
        delta_y_next     = dy_start;
        if (dx_start > dy_start) begin
          error_term_next = $signed({2'b00, dx_start >> 1});
        end else begin
          error_term_next = -$signed({2'b00, dy_start >> 1});
        end
        held_colour_next = line_colour;
        line_active_next = 1'b1;
      end
      CMD_NEXT: begin
        if (line_active) begin
          if (take_x) begin
            cur_x_next = step_x_neg ? cur_x - CB'(1) : cur_x + CB'(1);
          end
          if (take_y) begin
            cur_y_next = step_y_neg ? cur_y - CB'(1) : cur_y + CB'(1);
          end
          error_term_next = error_term - (take_x ? dy_s : ERRW'(0))
                                       + (take_y ? dx_s : ERRW'(0));
        end
      end
      default: begin
      end
    endcase

    // pixel out, or an empty result with no line active
    if ((cmd == CMD_NEXT) && !line_active) begin
      s1_pv_next     = 1'b0;
      s1_x_next      = '0;
      s1_y_next      = '0;
      s1_colour_next = '0;
      s1_last_next   = 1'b0;
    end else begin
      s1_pv_next     = 1'b1;
      s1_x_next      = cur_x_next;
      s1_y_next      = cur_y_next;
      s1_colour_next = held_colour_next;
      s1_last_next   = (cur_x_next == target_x_next) && (cur_y_next == target_y_next);
      if (s1_last_next) begin
        line_active_next = 1'b0;
      end
    end
  end

  // state and stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      target_x    <= '0;
      target_y    <= '0;
      delta_x     <= '0;
      delta_y     <= '0;
      step_x_neg  <= 1'b0;
      step_y_neg  <= 1'b0;
      error_term  <= '0;
      held_colour <= '0;
      line_active <= 1'b0;
      s1_v        <= 1'b0;
    end else if (in_fire) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      target_x    <= target_x_next;
      target_y    <= target_y_next;
      delta_x     <= delta_x_next;
      delta_y     <= delta_y_next;
      step_x_neg  <= step_x_neg_next;
      step_y_neg  <= step_y_neg_next;
      error_term  <= error_term_next;
      held_colour <= held_colour_next;
      line_active <= line_active_next;
      s1_v        <= 1'b1;
    end else if (out_en) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pv     <= s1_pv_next;
      s1_x      <= s1_x_next;
      s1_y      <= s1_y_next;
      s1_colour <= s1_colour_next;
      s1_last   <= s1_last_next;
    end
  end

  // stage 2: linear index, y * width + x, wrapped to the field width
  logic [PRODW-1:0] index_sum;
  logic [WIDE-1:0]  px_w, py_w;
  assign index_sum = PRODW'(s1_y) * PRODW'(line_pitch) + PRODW'(s1_x);
  assign px_w      = WIDE'(s1_x);
  assign py_w      = WIDE'(s1_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_v) begin
      pixel_valid  <= s1_pv;
      pixel_x      <= px_w[COORD_W-1:0];
      pixel_y      <= py_w[COORD_W-1:0];
      pixel_index  <= index_sum[INDEX_W-1:0];
      pixel_colour <= s1_colour;
      last_pixel   <= s1_last;
    end
  end

endmodule

// ===== hw/rtl/lpg_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the pixel channel.
module lpg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          pixel_valid,
  input logic [lpg_pkg::COORD_W-1:0]   pixel_x,
  input logic [lpg_pkg::COORD_W-1:0]   pixel_y,
  input logic [lpg_pkg::INDEX_W-1:0]   pixel_index,
  input logic [lpg_pkg::COLOUR_W-1:0]  pixel_colour,
  input logic                          last_pixel
);

  // a stalled result holds
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
            out_valid && $stable(pixel_x) && $stable(pixel_y) &&
            $stable(pixel_index) && $stable(pixel_colour) && $stable(last_pixel),
            "stalled pixel changed")

  // an empty result carries all zero fields
  `CHK_IMPLY(a_empty_zero, clk, rst, out_valid && !pixel_valid,
             pixel_x == '0 && pixel_y == '0 && pixel_index == '0 &&
             pixel_colour == '0 && !last_pixel,
             "empty result not cleared")

  // last is only flagged on a real pixel
  `CHK_IMPLY(a_last_valid, clk, rst, out_valid && last_pixel, pixel_valid, "last flag on empty result")

  // pipeline comes out of reset empty
  `CHK_IMPLY(a_reset_empty, clk, rst, $past(rst), !out_valid, "result present after reset")

endmodule

bind line_pixel_generator_core lpg_checker u_lpg_checker (.*);
